### hw/rtl/ipv4dd_pkg.sv
// ipv4dd_pkg: shared types, character codes and helper functions for the
// dotted-decimal IPv4 parser. No dependencies.

package ipv4dd_pkg;

    // Character codes
    localparam logic [7:0] C_CHAR_NUL  = 8'h00;
    localparam logic [7:0] C_CHAR_ZERO = 8'h30;  // '0'
    localparam logic [7:0] C_CHAR_NINE = 8'h39;  // '9'
    localparam logic [7:0] C_CHAR_DOT  = 8'h2E;  // '.'

    // Part and dot limits
    localparam int unsigned PART_W  = 9;
    localparam int unsigned DOT_W   = 3;
    localparam int unsigned SUM_W   = 12;        // part * 10 + digit fits here
    localparam logic [PART_W-1:0] C_PART_SAT = 9'd256;
    localparam logic [DOT_W-1:0]  C_MAX_DOTS = 3'd3;
    localparam logic [DOT_W-1:0]  C_DOT_SAT  = 3'd4;

    // Character classes
    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_DOT   = 2'd1,
        CLS_END   = 2'd2,
        CLS_OTHER = 2'd3
    } t_char_class;

    // Contents of the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] character;
    } t_in_stage;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class cls;
        if (c inside {[C_CHAR_ZERO:C_CHAR_NINE]}) begin
            cls = CLS_DIGIT;
        end else if (c == C_CHAR_DOT) begin
            cls = CLS_DOT;
        end else if (c == C_CHAR_NUL) begin
            cls = CLS_END;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### hw/rtl/ipv4dd_char_if.sv
// ipv4dd_char_if: valid/ready channel carrying one string character per
// transaction. No dependencies.

interface ipv4dd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

### hw/rtl/ipv4dd_res_if.sv
// ipv4dd_res_if: valid/ready channel carrying one parse result (ok flag and
// address) per transaction. No dependencies.

interface ipv4dd_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] address;

    modport source (output valid, output ok, output address, input ready);
    modport sink   (input valid, input ok, input address, output ready);
endinterface

### hw/rtl/ipv4dd_in_stage.sv
// ipv4dd_in_stage: input register for the character channel.
// Depends on ipv4dd_pkg and ipv4dd_char_if.

module ipv4dd_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipv4dd_char_if.sink           i_char,
    input  logic                  i_advance,
    output ipv4dd_pkg::t_in_stage o_stage
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_character;
    logic       accept;

    // Take a new character when empty or when the held one moves on
    assign i_char.ready = !r_valid || i_advance;
    assign accept       = i_char.valid && i_char.ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_character <= i_char.character;
        end
    end

    assign o_stage.valid     = r_valid;
    assign o_stage.character = r_character;

endmodule

### hw/rtl/ipv4dd_parse.sv
// ipv4dd_parse: parse state update and result register.
// Depends on ipv4dd_pkg and ipv4dd_res_if.

module ipv4dd_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_network_order,
    input  ipv4dd_pkg::t_in_stage i_stage,
    output logic                  o_advance,
    ipv4dd_res_if.source          o_res
);

    localparam int unsigned PW = ipv4dd_pkg::PART_W;
    localparam int unsigned DW = ipv4dd_pkg::DOT_W;
    localparam int unsigned SW = ipv4dd_pkg::SUM_W;

    logic [PW-1:0] r_part;
    logic [PW-1:0] n_part;
    logic [DW-1:0] r_dots;
    logic [DW-1:0] n_dots;
    logic [31:0]   r_acc;
    logic [31:0]   n_acc;
    logic          r_err;
    logic          n_err;

    logic          r_out_valid;
    logic          r_out_ok;
    logic [31:0]   r_out_address;
    logic          n_out_ok;
    logic [31:0]   n_out_address;

    ipv4dd_pkg::t_char_class cls;
    logic [SW-1:0] digit_sum;
    logic [DW-1:0] dots_inc;
    logic          part_big;
    logic [31:0]   closed_acc;
    logic [31:0]   aligned;
    logic          is_end;

    assign cls    = ipv4dd_pkg::classify(i_stage.character);
    assign is_end = (cls == ipv4dd_pkg::CLS_END);

    // A NUL needs room in the result register; other characters always move
    assign o_advance = i_stage.valid && (!is_end || !r_out_valid || o_res.ready);

    // part * 10 + digit
    assign digit_sum = ({{(SW-PW){1'b0}}, r_part} << 3)
                     + ({{(SW-PW){1'b0}}, r_part} << 1)
                     + {{(SW-4){1'b0}}, i_stage.character[3:0]};

    assign part_big   = r_part[PW-1];            // only 256 sets the top bit
    assign closed_acc = {r_acc[23:0], r_part[7:0]};
    assign dots_inc   = (r_dots <= ipv4dd_pkg::C_MAX_DOTS) ? r_dots + DW'(1) : r_dots;

    // Left-align when fewer than three dots were seen
    always_comb begin
        case (r_dots)
            3'd0:    aligned = closed_acc << 24;
            3'd1:    aligned = closed_acc << 16;
            3'd2:    aligned = closed_acc << 8;
            default: aligned = closed_acc;
        endcase
    end

    // Next parse state
    always_comb begin
        n_part = r_part;
        n_dots = r_dots;
        n_acc  = r_acc;
        n_err  = r_err;
        case (cls)
            ipv4dd_pkg::CLS_DIGIT: begin
                if (digit_sum > {{(SW-PW){1'b0}}, ipv4dd_pkg::C_PART_SAT}) begin
                    n_part = ipv4dd_pkg::C_PART_SAT;
                end else begin
                    n_part = digit_sum[PW-1:0];
                end
            end
            ipv4dd_pkg::CLS_DOT: begin
                n_dots = dots_inc;
                n_part = '0;
                if (dots_inc > ipv4dd_pkg::C_MAX_DOTS || part_big) begin
                    n_err = 1'b1;
                end else begin
                    n_acc = closed_acc;
                end
            end
            ipv4dd_pkg::CLS_END: begin
                n_part = '0;
                n_dots = '0;
                n_acc  = '0;
                n_err  = 1'b0;
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // Result at end of string
    always_comb begin
        n_out_ok      = !(r_err || part_big);
        n_out_address = '0;
        if (n_out_ok) begin
            n_out_address = i_network_order ? ipv4dd_pkg::swap32(aligned) : aligned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part      <= '0;
            r_dots      <= '0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_part <= n_part;
                r_dots <= n_dots;
                r_acc  <= n_acc;
                r_err  <= n_err;
            end
            if (o_advance && is_end) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_advance && is_end) begin
            r_out_ok      <= n_out_ok;
            r_out_address <= n_out_address;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.ok      = r_out_ok;
    assign o_res.address = r_out_address;

    // Checks
    a_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part <= ipv4dd_pkg::C_PART_SAT)
        else $error("part accumulator above saturation value");

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dots <= ipv4dd_pkg::C_DOT_SAT)
        else $error("dot count above saturation value");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && is_end) |=> (r_part == '0 && r_dots == '0 && r_acc == '0 && !r_err))
        else $error("parse state not cleared after end of string");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && is_end) |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten before transaction");

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_address == '0))
        else $error("failed parse carries nonzero address");

endmodule

### hw/rtl/ipv4dd_pkg_top_placeholder.sv
// ipv4dd_cfg: network-order configuration register.
// Depends on nothing outside this file.

module ipv4dd_cfg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    output logic o_network_order
);

    logic r_network_order;

    // The user must write it only while idle; the block does not enforce this; no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_network_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_network_order <= i_cfg_wr_data;
        end
    end

    assign o_network_order = r_network_order;

endmodule

### hw/rtl/ipv4_dotted_decimal_parser_core.sv
// ipv4_dotted_decimal_parser_core: streaming dotted-decimal IPv4 parser.
// Depends on ipv4dd_pkg, ipv4dd_char_if, ipv4dd_res_if, ipv4dd_in_stage,
// ipv4dd_parse and ipv4dd_cfg.
//
//   Channel  Dir  Payload                     Transaction
//   i_char   in   character[7:0]              one string character, NUL ends
//   o_res    out  ok, address[31:0]           one result per NUL
//   cfg      in   i_cfg_wr_data (1 bit)       write when i_cfg_wr_en is high
//
// One character per cycle sustained while no NUL waits on a stalled result. An
// accepted NUL loads the input register, and its result then loads the result register
// once that register is free. Synchronous active-low reset clears parse state, both
// valid flags and the network_order bit. A stalled result blocks a following NUL, and
// the characters behind that NUL wait with it; characters ahead of it keep flowing.

module ipv4_dotted_decimal_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    ipv4dd_char_if.sink   i_char,
    ipv4dd_res_if.source  o_res
);

    ipv4dd_pkg::t_in_stage stage;
    logic                  advance;
    logic                  network_order;

    ipv4dd_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_network_order (network_order)
    );

    ipv4dd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_advance (advance),
        .o_stage   (stage)
    );

    ipv4dd_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_network_order (network_order),
        .i_stage         (stage),
        .o_advance       (advance),
        .o_res           (o_res)
    );

endmodule
